[sv/igds_pkg.sv]
// Shared constants and helpers for the isotropic gamma direction sampler.
// Holds the quarter-wave sine coefficients, the Q1.15 limits and the
// saturation function; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package igds_pkg;

  // Q30 format: one quarter turn and unity
  localparam int unsigned Q30_BITS = 30;
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;

  // Taylor coefficients of sin(pi/2 * x) in Q30, lowest order first
  localparam int unsigned NUM_COEF = 5;
  localparam logic [30:0] SIN_COEF [NUM_COEF] = '{
    31'd1686629713, 31'd693598669, 31'd85569306, 31'd5026995, 31'd172272
  };

  // Rounding constant for Q1.15 results and the direction limits
  localparam logic [14:0] HALF_LSB = 15'h4000;
  localparam logic [15:0] DIR_MAX  = 16'h7FFF;
  localparam logic [15:0] DIR_MIN  = 16'h8000;

  // Number of square root steps done in one stage
  localparam int unsigned SQRT_STEPS_PER_STAGE = 3;
  localparam int unsigned SQRT_STEPS           = 16;

  // Apply a sign to a magnitude and clamp to Q1.15
  function automatic logic [15:0] sat_dir(input logic [18:0] mag, input logic neg);
    logic [15:0] res;
    if (neg) begin
      if (mag > 19'd32768) begin
        res = DIR_MIN;
      end else begin
        res = 16'(-mag[15:0]);
      end
    end else begin
      if (mag > 19'd32767) begin
        res = DIR_MAX;
      end else begin
        res = mag[15:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/isotropic_gamma_direction_sampler_unit.sv]
// Top level of the isotropic gamma direction sampler: a nine-stage pipeline.
// Depends on igds_pkg for coefficients, limits and saturation.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction of three uniform fractions per cycle and returns one
// result for each: the photon energy (excitation energy times the first
// fraction, truncated) and an isotropic unit direction in signed Q1.15.
// Throughput is one item per clock. The chain of six multiplies in the
// Horner sine evaluation runs in parallel with a sixteen-step restoring
// square root spread over six stages. The whole pipeline advances together;
// it holds only while a result waits at the output and out_ready_i is low.
// excitation_energy is written through cfg_we_i / cfg_wdata_i and resets
// to zero.
module isotropic_gamma_direction_sampler_unit #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned ENERGY_BITS   = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [ENERGY_BITS-1:0]   cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [FRACTION_BITS-1:0] energy_fraction_i,
  input  wire logic [FRACTION_BITS-1:0] polar_fraction_i,
  input  wire logic [FRACTION_BITS-1:0] azimuth_fraction_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ENERGY_BITS-1:0]        photon_energy_o,
  output logic signed [15:0]            dir_x_o,
  output logic signed [15:0]            dir_y_o,
  output logic signed [15:0]            dir_z_o
);

  localparam int unsigned NST  = 9;  // pipeline depth
  localparam int unsigned PROD = ENERGY_BITS + FRACTION_BITS;

  // excitation energy register
  logic [ENERGY_BITS-1:0] exc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exc_q <= '0;
    end else if (cfg_we_i) begin
      exc_q <= cfg_wdata_i;
    end
  end

  // global advance: move when the output slot is free or being taken
  logic adv;
  logic [NST:1] vld_q;

  assign adv         = !vld_q[NST] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-1:1], in_valid_i};
    end
  end

  // stage 1 inputs: scale fractions, energy product, sqrt radicand
  logic [FRACTION_BITS+15:0] f2_wide;
  logic [FRACTION_BITS+31:0] f3_wide;
  logic [15:0]               t16;
  logic [31:0]               phase;
  logic [PROD-1:0]           nrg_prod;
  logic [32:0]               rad_prod;
  logic signed [16:0]        zc_d;
  logic [30:0]               xa_d, xb_d;

  always_comb begin
    f2_wide  = {polar_fraction_i, 16'h0000};
    f3_wide  = {azimuth_fraction_i, 32'h0000_0000};
    t16      = f2_wide[FRACTION_BITS+15 -: 16];
    phase    = f3_wide[FRACTION_BITS+31 -: 32];
    nrg_prod = PROD'(exc_q) * PROD'(energy_fraction_i);
    // 2^30 - zc^2 equals t * (2^16 - t)
    rad_prod = 33'(t16) * (33'h1_0000 - 33'(t16));
    zc_d     = 17'sh0_8000 - signed'({1'b0, t16});
    xa_d     = {1'b0, phase[29:0]};
    xb_d     = igds_pkg::Q30_ONE - xa_d;
  end

  // carried fields
  logic [ENERGY_BITS-1:0] nrg_q  [1:8];
  logic signed [16:0]     zc_q   [1:8];
  logic [1:0]             quad_q [1:7];
  logic [30:0]            rad_q;
  logic [30:0]            x_q    [1:6][2];   // lane 0 sine, lane 1 cosine
  logic [30:0]            x2_q   [2:6][2];
  logic [30:0]            acc_q  [3:6][2];
  logic [16:0]            mag_q  [2];
  logic [31:0]            srem_q [2:7];
  logic [31:0]            sres_q [2:7];
  logic [32:0]            dprod_q [2];       // 0: x, 1: y
  logic                   dneg_q  [2];

  // square root: restoring steps, three per stage
  logic [31:0] srem_d [2:7];
  logic [31:0] sres_d [2:7];

  always_comb begin : sqrt_comb
    logic [31:0] rem;
    logic [31:0] res;
    logic [31:0] bt;
    int unsigned it;
    for (int j = 2; j <= 7; j++) begin
      if (j == 2) begin
        rem = {1'b0, rad_q};
        res = '0;
      end else begin
        rem = srem_q[j-1];
        res = sres_q[j-1];
      end
      for (int k = 0; k < igds_pkg::SQRT_STEPS_PER_STAGE; k++) begin
        it = (j - 2) * igds_pkg::SQRT_STEPS_PER_STAGE + k;
        if (it < igds_pkg::SQRT_STEPS) begin
          bt = 32'h1 << (2 * (igds_pkg::SQRT_STEPS - 1 - it));
          if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
          end else begin
            res = res >> 1;
          end
        end
      end
      srem_d[j] = rem;
      sres_d[j] = res;
    end
  end

  // sine polynomial: square, Horner steps, final multiply, rounding
  logic [61:0] sq_prod [2];
  logic [30:0] acc_d   [3:6][2];
  logic [61:0] fin_prod [2];
  logic [31:0] fin_rnd  [2];

  always_comb begin : poly_comb
    logic [30:0] prev;
    logic [61:0] pp;
    for (int l = 0; l < 2; l++) begin
      sq_prod[l] = 62'(x_q[1][l]) * 62'(x_q[1][l]);
      for (int m = 0; m < 4; m++) begin
        prev = (m == 0) ? igds_pkg::SIN_COEF[4] : acc_q[2+m][l];
        pp   = 62'(prev) * 62'(x2_q[2+m][l]);
        acc_d[3+m][l] = igds_pkg::SIN_COEF[3-m] - pp[60:30];
      end
      fin_prod[l] = 62'(acc_q[6][l]) * 62'(x_q[6][l]);
      fin_rnd[l]  = 32'(fin_prod[l][60:30]) + 32'(igds_pkg::HALF_LSB);
    end
  end

  // quadrant select and products with sin theta
  logic [16:0] sin_mag, cos_mag;
  logic [15:0] s_mag;
  logic [33:0] rnd_x, rnd_y;

  always_comb begin
    sin_mag = quad_q[7][0] ? mag_q[1] : mag_q[0];
    cos_mag = quad_q[7][0] ? mag_q[0] : mag_q[1];
    s_mag   = sres_q[7][15:0];
    rnd_x   = 34'(dprod_q[0]) + 34'(igds_pkg::HALF_LSB);
    rnd_y   = 34'(dprod_q[1]) + 34'(igds_pkg::HALF_LSB);
  end

  // pipeline payload registers
  logic [ENERGY_BITS-1:0] nrg_out_q;
  logic [15:0]            dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      nrg_q[1]    <= nrg_prod[FRACTION_BITS +: ENERGY_BITS];
      zc_q[1]     <= zc_d;
      quad_q[1]   <= phase[31:30];
      rad_q       <= rad_prod[30:0];
      x_q[1][0]   <= xa_d;
      x_q[1][1]   <= xb_d;
      // carry along
      for (int i = 2; i <= 8; i++) begin
        nrg_q[i] <= nrg_q[i-1];
        zc_q[i]  <= zc_q[i-1];
      end
      for (int i = 2; i <= 7; i++) begin
        quad_q[i] <= quad_q[i-1];
        srem_q[i] <= srem_d[i];
        sres_q[i] <= sres_d[i];
      end
      for (int l = 0; l < 2; l++) begin
        for (int i = 2; i <= 6; i++) begin
          x_q[i][l] <= x_q[i-1][l];
        end
        x2_q[2][l] <= sq_prod[l][60:30];
        for (int i = 3; i <= 6; i++) begin
          x2_q[i][l]  <= x2_q[i-1][l];
          acc_q[i][l] <= acc_d[i][l];
        end
        mag_q[l] <= fin_rnd[l][31:15];
      end
      // stage 8: direction magnitude products and their signs
      dprod_q[0] <= 33'(cos_mag) * 33'(s_mag);
      dprod_q[1] <= 33'(sin_mag) * 33'(s_mag);
      dneg_q[0]  <= quad_q[7][1] ^ quad_q[7][0];
      dneg_q[1]  <= quad_q[7][1];
      // stage 9: round, sign and saturate
      nrg_out_q <= nrg_q[8];
      dx_q      <= igds_pkg::sat_dir(rnd_x[33:15], dneg_q[0]);
      dy_q      <= igds_pkg::sat_dir(rnd_y[33:15], dneg_q[1]);
      dz_q      <= (zc_q[8] > 17'sh0_7FFF) ? igds_pkg::DIR_MAX : zc_q[8][15:0];
    end
  end

  assign photon_energy_o = nrg_out_q;
  assign dir_x_o         = signed'(dx_q);
  assign dir_y_o         = signed'(dy_q);
  assign dir_z_o         = signed'(dz_q);

endmodule

`default_nettype wire

[sv/igds_checker.sv]
// Port-level checker for the isotropic gamma direction sampler, with its bind.
// Depends on igds_pkg and sees only the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module igds_port_checker #(
  parameter int unsigned ENERGY_BITS = 24
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [ENERGY_BITS-1:0] photon_energy_o,
  input wire logic signed [15:0]     dir_x_o,
  input wire logic signed [15:0]     dir_y_o,
  input wire logic signed [15:0]     dir_z_o
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(photon_energy_o)
      && $stable(dir_x_o) && $stable(dir_y_o) && $stable(dir_z_o))
    else $error("stalled result changed");

  // pipeline takes input whenever the output slot is free or drains
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // cos theta never reaches minus one at 16-bit phase resolution
  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dir_z_o != igds_pkg::DIR_MIN)
    else $error("dir_z out of range");

  // near the pole the transverse part stays within one step of sin theta
  a_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dir_z_o == igds_pkg::DIR_MAX |->
      dir_x_o <= 16'sd255 && dir_x_o >= -16'sd255 &&
      dir_y_o <= 16'sd255 && dir_y_o >= -16'sd255)
    else $error("transverse part at the pole");

endmodule

bind isotropic_gamma_direction_sampler_unit igds_port_checker #(
  .ENERGY_BITS(ENERGY_BITS)
) u_igds_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .photon_energy_o(photon_energy_o),
  .dir_x_o        (dir_x_o),
  .dir_y_o        (dir_y_o),
  .dir_z_o        (dir_z_o)
);

`default_nettype wire

[tb/igds_checker.sv]
// Checker for the isotropic gamma direction sampler: watches both channels,
// predicts energy and direction for each accepted transaction and compares.
// Depends on igds_pkg only for the Q1.15 limits.
`timescale 1ns / 1ps
`default_nettype none

module igds_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [15:0] energy_fraction_i,
  input  wire logic [15:0] polar_fraction_i,
  input  wire logic [15:0] azimuth_fraction_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [23:0] photon_energy_i,
  input  wire logic [15:0] dir_x_i,
  input  wire logic [15:0] dir_y_i,
  input  wire logic [15:0] dir_z_i,
  output int               mismatches_o,
  output int               pending_o
);

  typedef struct packed {
    logic [23:0] energy;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } photon_t;

  photon_t     photon_q[$];
  logic [23:0] excitation;

  localparam longint COEF [5] = '{1686629713, 693598669, 85569306, 5026995, 172272};

  function automatic longint root_floor(longint v);
    longint r;
    r = 0;
    for (longint b = 32768; b > 0; b = b >> 1)
      if ((r + b) * (r + b) <= v) r = r + b;
    return r;
  endfunction

  // sin(pi/2 * x / 2^30) in Q1.15
  function automatic longint quarter_wave(longint x);
    longint x2, acc;
    x2 = (x * x) >>> 30;
    acc = COEF[4];
    for (int k = 3; k >= 0; k--) acc = COEF[k] - ((acc * x2) >>> 30);
    acc = (acc * x) >>> 30;
    return (acc + 16384) >>> 15;
  endfunction

  function automatic logic [15:0] clamp(longint v);
    if (v > 32767) return igds_pkg::DIR_MAX;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] scaled(longint a, longint b, bit neg);
    longint m;
    m = (a * b + 16384) >>> 15;
    return clamp(neg ? -m : m);
  endfunction

  function automatic photon_t predict_photon(logic [15:0] f1, logic [15:0] f2,
                                             logic [15:0] f3);
    photon_t p;
    longint zc, s, xr, xs, xc, sm, cm;
    bit sn, cn;
    logic [1:0] quad;
    p.energy = 24'((longint'(excitation) * f1) >> 16);
    zc = 32768 - longint'(f2);
    s = root_floor(64'd1073741824 - zc * zc);
    quad = f3[15:14];
    xr = longint'(f3[13:0]) << 16;
    xs = quarter_wave(xr);
    xc = quarter_wave(64'd1073741824 - xr);
    case (quad)
      2'd0: begin sm = xs; sn = 0; cm = xc; cn = 0; end
      2'd1: begin sm = xc; sn = 0; cm = xs; cn = 1; end
      2'd2: begin sm = xs; sn = 1; cm = xc; cn = 1; end
      default: begin sm = xc; sn = 1; cm = xs; cn = 0; end
    endcase
    p.x = scaled(cm, s, cn);
    p.y = scaled(sm, s, sn);
    p.z = clamp(zc);
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches_o++;
  endtask

  initial begin
    mismatches_o = 0;
    excitation = '0;
  end

  assign pending_o = photon_q.size();

  // Track the register, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    photon_t want;
    if (!rst_ni) begin
      excitation <= '0;
    end else begin
      if (cfg_we_i) excitation <= cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        photon_q.push_back(predict_photon(energy_fraction_i, polar_fraction_i,
                                          azimuth_fraction_i));
      if (out_valid_i && out_ready_i) begin
        if (photon_q.size() == 0) begin
          report_mismatch("unexpected transaction", '0, '0);
        end else begin
          want = photon_q.pop_front();
          if (photon_energy_i !== want.energy)
            report_mismatch("photon_energy", photon_energy_i, want.energy);
          if (dir_x_i !== want.x) report_mismatch("dir_x", dir_x_i, want.x);
          if (dir_y_i !== want.y) report_mismatch("dir_y", dir_y_i, want.y);
          if (dir_z_i !== want.z) report_mismatch("dir_z", dir_z_i, want.z);
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Top of the sampler testbench: clock, reset, register writes, stimulus,
// receiver stalls and verdict. Depends on the sampler RTL and igds_checker.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [15:0] energy_fraction_i = '0;
  logic [15:0] polar_fraction_i = '0;
  logic [15:0] azimuth_fraction_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [23:0] photon_energy_o;
  logic [15:0] dir_x_o, dir_y_o, dir_z_o;
  int          mismatches, pending, idle_cycles;
  bit          hold_off = 0;

  localparam int WATCHDOG = 5000;

  always #5 clk_i = ~clk_i;

  isotropic_gamma_direction_sampler_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .energy_fraction_i, .polar_fraction_i, .azimuth_fraction_i,
    .out_valid_o, .out_ready_i, .photon_energy_o, .dir_x_o, .dir_y_o, .dir_z_o
  );

  igds_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .energy_fraction_i, .polar_fraction_i,
    .azimuth_fraction_i, .out_valid_i(out_valid_o), .out_ready_i,
    .photon_energy_i(photon_energy_o), .dir_x_i(dir_x_o), .dir_y_i(dir_y_o),
    .dir_z_i(dir_z_o), .mismatches_o(mismatches), .pending_o(pending)
  );

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Bias fractions toward their edges now and then
  function automatic logic [15:0] fraction();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {2'($urandom_range(0, 3)), 14'h0};
      3: return 16'(16'h8000 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom());
    endcase
  endfunction

  // Offer one transaction; valid stays high into the next one when there is no gap
  task automatic send_sample(logic [15:0] f1, logic [15:0] f2, logic [15:0] f3);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    energy_fraction_i <= f1;
    polar_fraction_i <= f2;
    azimuth_fraction_i <= f3;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Wait until every expected transaction is back, let the pipe drain, then write the register
  task automatic drain_and_write(logic [23:0] energy);
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= energy;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Receiver: random stalls, with one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (60) @(negedge clk_i);
        hold_off = 0;
      end
      out_ready_i <= (gap_length() == 0);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [23:0] energies [6];
    logic [15:0] edges [6];
    idle_cycles = 0;
    energies = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000, 24'h123456, 24'h0};
    edges = '{16'h0000, 16'hFFFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: zero energy at reset, then full energy with edge fractions
    send_sample(16'hFFFF, 16'h0000, 16'h0000);
    drain_and_write(24'hFFFFFF);
    for (int i = 0; i < 6; i++) send_sample(edges[i], edges[i], edges[(i + 2) % 6]);
    for (int i = 0; i < 6; i++) send_sample(16'hFFFF, edges[(i + 1) % 6], edges[i]);

    // Random phases across several register settings
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_write(ph == 5 ? 24'($urandom()) : energies[ph]);
      if (ph == 2) hold_off = 1;
      for (int n = 0; n < 125; n++) send_sample(fraction(), fraction(), fraction());
    end

    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
